// ===== hw/rtl/icv_pkg.sv =====
// Shared types, constants and codes for the interval convolution block.
package icv_pkg;

   localparam int MAX_IN_DIM     = 64;
   localparam int MAX_KERNEL_DIM = 8;
   localparam int VALUE_BITS     = 32;
   localparam int FRACTION_BITS  = 16;

   localparam int IN_AW   = 6;   // log2 of MAX_IN_DIM
   localparam int K_AW    = 3;   // log2 of MAX_KERNEL_DIM
   localparam int PROD_W  = 2 * VALUE_BITS;
   localparam int SHIFT_W = PROD_W - FRACTION_BITS;

   // request actions
   localparam logic [1:0] ACT_LOAD_INPUT  = 2'd0;
   localparam logic [1:0] ACT_LOAD_KERNEL = 2'd1;
   localparam logic [1:0] ACT_COMPUTE     = 2'd2;

   // result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_KERNEL   = 2'd1;
   localparam logic [1:0] STS_POSITION = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_IN_ROWS   = 3'd0;
   localparam logic [2:0] CSR_IN_COLS   = 3'd1;
   localparam logic [2:0] CSR_TAPS_ROWS = 3'd2;
   localparam logic [2:0] CSR_TAPS_COLS = 3'd3;
   localparam logic [2:0] CSR_STEP_SIZE = 3'd4;
   localparam logic [2:0] CSR_PAD_WIDTH = 3'd5;

   typedef struct packed {
      logic [1:0]         action;
      logic [6:0]         row;
      logic [6:0]         col;
      logic signed [31:0] value_low;
      logic signed [31:0] value_high;
   } req_type;

   typedef struct packed {
      logic [6:0]         out_row;
      logic [6:0]         out_col;
      logic signed [31:0] result_low;
      logic signed [31:0] result_high;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RUN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic            capture;
      logic            decode;
      logic            issue;
      logic [K_AW-1:0] tap_row;
      logic [K_AW-1:0] tap_col;
      logic            emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0]      action;
      logic [1:0]      status;
      logic [K_AW-1:0] last_row;
      logic [K_AW-1:0] last_col;
      logic            rsp_full;
   } stat_type;

endpackage

// ===== hw/rtl/icv_ctrl.sv =====
// Controller: sequences decode, the kernel tap walk, pipeline drain and result.
module icv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  icv_pkg::stat_type  stat,
   output icv_pkg::cmd_type   cmd
);

   icv_pkg::state_type state_ff, state_in;
   logic [icv_pkg::K_AW-1:0] a_ff, a_in, b_ff, b_in;
   logic [1:0] drain_ff, drain_in;

   // hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icv_pkg::ST_IDLE;
         a_ff     <= '0;
         b_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         drain_ff <= drain_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      drain_in    = drain_ff;
      req_stall   = 1'b1;
      cmd         = '0;
      cmd.tap_row = a_ff;
      cmd.tap_col = b_ff;
      unique case (state_ff)
         icv_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = icv_pkg::ST_DECODE;
            end
         end
         icv_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
            a_in       = '0;
            b_in       = '0;
            if (stat.action != icv_pkg::ACT_COMPUTE) begin
               state_in = icv_pkg::ST_IDLE;
            end else if (stat.status != icv_pkg::STS_OK) begin
               state_in = icv_pkg::ST_RESULT;
            end else begin
               state_in = icv_pkg::ST_RUN;
            end
         end
         icv_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            if (b_ff == stat.last_col) begin
               b_in = '0;
               a_in = a_ff + 1'b1;
               if (a_ff == stat.last_row) begin
                  drain_in = '0;
                  state_in = icv_pkg::ST_DRAIN;
               end
            end else begin
               b_in = b_ff + 1'b1;
            end
         end
         icv_pkg::ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd2) begin
               state_in = icv_pkg::ST_RESULT;
            end
         end
         icv_pkg::ST_RESULT: begin
            if (!stat.rsp_full) begin
               cmd.emit = 1'b1;
               state_in = icv_pkg::ST_IDLE;
            end
         end
         default: state_in = icv_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/icv_datapath.sv =====
// Datapath: config registers, stores, interval multiply-accumulate, result register.
module icv_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_data,
   input  icv_pkg::req_type   req_data,
   input  icv_pkg::cmd_type   cmd,
   output icv_pkg::stat_type  stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output icv_pkg::rsp_type   rsp_data
);

   localparam int DEPTH_IN = icv_pkg::MAX_IN_DIM * icv_pkg::MAX_IN_DIM;
   localparam int DEPTH_K  = icv_pkg::MAX_KERNEL_DIM * icv_pkg::MAX_KERNEL_DIM;

   logic [6:0] in_rows_ff, in_cols_ff;
   logic [3:0] taps_rows_ff, taps_cols_ff, step_size_ff;
   logic [2:0] pad_width_ff;
   logic       rsp_valid_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_rows_ff   <= 7'd1;
         in_cols_ff   <= 7'd1;
         taps_rows_ff <= 4'd1;
         taps_cols_ff <= 4'd1;
         step_size_ff <= 4'd1;
         pad_width_ff <= 3'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            icv_pkg::CSR_IN_ROWS:   in_rows_ff   <= csr_data;
            icv_pkg::CSR_IN_COLS:   in_cols_ff   <= csr_data;
            icv_pkg::CSR_TAPS_ROWS: taps_rows_ff <= csr_data[3:0];
            icv_pkg::CSR_TAPS_COLS: taps_cols_ff <= csr_data[3:0];
            icv_pkg::CSR_STEP_SIZE: step_size_ff <= csr_data[3:0];
            icv_pkg::CSR_PAD_WIDTH: pad_width_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // clamp sizes into their working ranges
   logic [6:0] ir, ic;
   logic [3:0] kr, kc, st;
   always_comb begin
      ir = (in_rows_ff == 7'd0) ? 7'd1 : (in_rows_ff > 7'd64) ? 7'd64 : in_rows_ff;
      ic = (in_cols_ff == 7'd0) ? 7'd1 : (in_cols_ff > 7'd64) ? 7'd64 : in_cols_ff;
      kr = (taps_rows_ff == 4'd0) ? 4'd1 : (taps_rows_ff > 4'd8) ? 4'd8 : taps_rows_ff;
      kc = (taps_cols_ff == 4'd0) ? 4'd1 : (taps_cols_ff > 4'd8) ? 4'd8 : taps_cols_ff;
      st = (step_size_ff == 4'd0) ? 4'd1 : step_size_ff;
   end

   // hold the accepted request
   icv_pkg::req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // check kernel fit and output position
   logic [7:0]  prad_r, prad_c;
   logic [10:0] rowpos, colpos;
   logic [11:0] need_r, need_c;
   logic        too_big, outside;
   always_comb begin
      prad_r  = {1'b0, ir} + {4'b0, pad_width_ff, 1'b0};
      prad_c  = {1'b0, ic} + {4'b0, pad_width_ff, 1'b0};
      rowpos  = 11'(req_ff.row) * 11'(st);
      colpos  = 11'(req_ff.col) * 11'(st);
      need_r  = {1'b0, rowpos} + {8'b0, kr};
      need_c  = {1'b0, colpos} + {8'b0, kc};
      too_big = (prad_r < {4'b0, kr}) || (prad_c < {4'b0, kc});
      outside = (need_r > {4'b0, prad_r}) || (need_c > {4'b0, prad_c});
      stat.action   = req_ff.action;
      stat.status   = too_big ? icv_pkg::STS_KERNEL :
                      outside ? icv_pkg::STS_POSITION : icv_pkg::STS_OK;
      stat.last_row = 3'(kr - 4'd1);
      stat.last_col = 3'(kc - 4'd1);
      stat.rsp_full = rsp_valid_ff;
   end

   // store writes
   logic wr_in, wr_k;
   logic [63:0] wr_entry;
   always_comb begin
      wr_entry = {req_ff.value_high, req_ff.value_low};
      wr_in = cmd.decode && (req_ff.action == icv_pkg::ACT_LOAD_INPUT)
              && (req_ff.row < ir) && (req_ff.col < ic);
      wr_k  = cmd.decode && (req_ff.action == icv_pkg::ACT_LOAD_KERNEL)
              && (req_ff.row < 7'(kr)) && (req_ff.col < 7'(kc));
   end

   // tap coordinates
   logic [12:0] ypos, xpos;
   logic        tap_inside;
   logic [2*icv_pkg::IN_AW-1:0] in_rd_addr;
   logic [2*icv_pkg::K_AW-1:0]  k_rd_addr;
   always_comb begin
      ypos = {2'b0, rowpos} + {10'b0, cmd.tap_row} - {10'b0, pad_width_ff};
      xpos = {2'b0, colpos} + {10'b0, cmd.tap_col} - {10'b0, pad_width_ff};
      tap_inside = !ypos[12] && (ypos < {6'b0, ir}) && !xpos[12] && (xpos < {6'b0, ic});
      in_rd_addr = {ypos[icv_pkg::IN_AW-1:0], xpos[icv_pkg::IN_AW-1:0]};
      k_rd_addr  = {cmd.tap_row, cmd.tap_col};
   end

   // input and kernel memories
   logic [63:0] in_mem [DEPTH_IN];
   logic [63:0] k_mem  [DEPTH_K];
   logic [63:0] in_q_ff, k_q_ff;
   always_ff @(posedge clock) begin
      if (wr_in) begin
         in_mem[{req_ff.row[icv_pkg::IN_AW-1:0], req_ff.col[icv_pkg::IN_AW-1:0]}] <= wr_entry;
      end
      in_q_ff <= in_mem[in_rd_addr];
   end
   always_ff @(posedge clock) begin
      if (wr_k) begin
         k_mem[{req_ff.row[icv_pkg::K_AW-1:0], req_ff.col[icv_pkg::K_AW-1:0]}] <= wr_entry;
      end
      k_q_ff <= k_mem[k_rd_addr];
   end

   // four bound products
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff, p0_in, p1_in, p2_in, p3_in;
   always_comb begin
      p0_in = $signed(in_q_ff[31:0])  * $signed(k_q_ff[31:0]);
      p1_in = $signed(in_q_ff[31:0])  * $signed(k_q_ff[63:32]);
      p2_in = $signed(in_q_ff[63:32]) * $signed(k_q_ff[31:0]);
      p3_in = $signed(in_q_ff[63:32]) * $signed(k_q_ff[63:32]);
   end
   always_ff @(posedge clock) begin
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      p3_ff <= p3_in;
   end

   // min and max, rounded down and up
   logic signed [63:0] mn, mx, mx_up;
   logic signed [icv_pkg::SHIFT_W-1:0] lo_sh_ff, hi_sh_ff;
   always_comb begin
      mn = p0_ff;
      mx = p0_ff;
      if (p1_ff < mn) mn = p1_ff;
      if (p2_ff < mn) mn = p2_ff;
      if (p3_ff < mn) mn = p3_ff;
      if (p1_ff > mx) mx = p1_ff;
      if (p2_ff > mx) mx = p2_ff;
      if (p3_ff > mx) mx = p3_ff;
      mx_up = mx + 64'sd65535;
   end
   always_ff @(posedge clock) begin
      lo_sh_ff <= mn[63:icv_pkg::FRACTION_BITS];
      hi_sh_ff <= mx_up[63:icv_pkg::FRACTION_BITS];
   end

   // tap valid flags through the pipeline
   logic v1_ff, v2_ff, v3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue && tap_inside;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // saturating accumulate
   logic signed [31:0] acc_lo_ff, acc_hi_ff, acc_lo_in, acc_hi_in;
   logic signed [48:0] sum_lo, sum_hi;
   always_comb begin
      sum_lo = 49'(acc_lo_ff) + 49'(lo_sh_ff);
      sum_hi = 49'(acc_hi_ff) + 49'(hi_sh_ff);
      acc_lo_in = (sum_lo > 49'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                  (sum_lo < -49'sh80000000) ? 32'sh80000000 : sum_lo[31:0];
      acc_hi_in = (sum_hi > 49'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                  (sum_hi < -49'sh80000000) ? 32'sh80000000 : sum_hi[31:0];
   end
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         acc_lo_ff <= '0;
         acc_hi_ff <= '0;
      end else if (v3_ff) begin
         acc_lo_ff <= acc_lo_in;
         acc_hi_ff <= acc_hi_in;
      end
   end

   // result register
   icv_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.out_row     <= req_ff.row;
         rsp_ff.out_col     <= req_ff.col;
         rsp_ff.result_low  <= acc_lo_ff;
         rsp_ff.result_high <= acc_hi_ff;
         rsp_ff.status      <= stat.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

// ===== hw/rtl/interval_conv2d_stride_pad_top.sv =====
// Top level: interval 2D convolution with stride and zero padding.
// Load request: decoded and written to its store, then the next request is taken in idle.
// Compute request: the result follows decode, the one-tap-per-cycle walk through the
//   shared multiply-accumulate pipe and its drain; the next request is taken after the emit.
// Rejected position or oversized kernel: result goes from decode to the result state, bounds zero;
//   a result still held under stall delays the new one. Synchronous reset clears control
//   and config (sizes 1, stride 1, pad 0); stores undefined.
module interval_conv2d_stride_pad_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  icv_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output icv_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [6:0]        csr_data
);

   icv_pkg::cmd_type  cmd;
   icv_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   icv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   icv_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/icv_checker.sv =====
// Port checker for the interval convolution top level, with its bind.
module icv_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input icv_pkg::rsp_type rsp_data
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // status code is defined
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("undefined status");

   // rejected request carries zero bounds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != icv_pkg::STS_OK |->
         rsp_data.result_low == 32'sd0 && rsp_data.result_high == 32'sd0)
      else $error("nonzero bounds on rejected request");

endmodule

bind interval_conv2d_stride_pad_top icv_checker u_icv_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/tb_interval_conv2d_stride_pad_top.sv =====
// Testbench for the interval 2D convolution block: directed and random loads and computes vs a predictor.
`timescale 1ns / 1ps
module tb_interval_conv2d_stride_pad_top;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   icv_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   icv_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [2:0]       csr_index;
   logic [6:0]       csr_data;

   interval_conv2d_stride_pad_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor state
   logic [63:0] image_mem [0:4095];
   logic [63:0] taps_mem [0:63];
   int unsigned cfg_rows, cfg_cols, cfg_krows, cfg_kcols, cfg_step, cfg_pad;

   icv_pkg::req_type pending_reqs[$];
   icv_pkg::rsp_type expected_sums[$];
   int          error_count;
   int          req_wait;
   int          rsp_wait;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb_interval_conv2d_stride_pad_top: errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic signed [63:0] clamp_value(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // floor / ceil shift by the fraction bits; >>> floors already
   function automatic logic signed [63:0] round_down(input logic signed [63:0] v);
      return v >>> icv_pkg::FRACTION_BITS;
   endfunction

   function automatic logic signed [63:0] round_up(input logic signed [63:0] v);
      return -((-v) >>> icv_pkg::FRACTION_BITS);
   endfunction

   // apply one request to the predictor state; return 1 with the sum for computes
   function automatic bit predict_sum(input icv_pkg::req_type r,
                                      output icv_pkg::rsp_type res);
      int unsigned kr, kc, st, pd, orow, ocol;
      int          yi, xj;
      logic signed [63:0] acc_lo, acc_hi, p0, p1, p2, p3, mn, mx;
      logic signed [31:0] xl, xh, kl, kh;
      logic [63:0] xe, ke;
      res = '0;
      acc_lo = 0;
      acc_hi = 0;
      kr = cfg_krows;
      kc = cfg_kcols;
      st = cfg_step;
      pd = cfg_pad;
      if (r.action == icv_pkg::ACT_LOAD_INPUT) begin
         if (r.row < cfg_rows && r.col < cfg_cols) begin
            image_mem[r.row * 64 + r.col] = {r.value_high, r.value_low};
         end
         return 1'b0;
      end
      if (r.action == icv_pkg::ACT_LOAD_KERNEL) begin
         if (r.row < kr && r.col < kc) begin
            taps_mem[r.row * 8 + r.col] = {r.value_high, r.value_low};
         end
         return 1'b0;
      end
      if (r.action != icv_pkg::ACT_COMPUTE) return 1'b0;
      res.out_row = r.row;
      res.out_col = r.col;
      if (cfg_rows + 2 * pd < kr || cfg_cols + 2 * pd < kc) begin
         res.status = icv_pkg::STS_KERNEL;
         return 1'b1;
      end
      orow = (cfg_rows + 2 * pd - kr) / st + 1;
      ocol = (cfg_cols + 2 * pd - kc) / st + 1;
      if (r.row >= orow || r.col >= ocol) begin
         res.status = icv_pkg::STS_POSITION;
         return 1'b1;
      end
      for (int a = 0; a < kr; a++) begin
         for (int b = 0; b < kc; b++) begin
            yi = r.row * st + a - pd;
            xj = r.col * st + b - pd;
            if (yi < 0 || yi >= cfg_rows || xj < 0 || xj >= cfg_cols) continue;
            xe = image_mem[yi * 64 + xj];
            ke = taps_mem[a * 8 + b];
            xl = xe[31:0];
            xh = xe[63:32];
            kl = ke[31:0];
            kh = ke[63:32];
            p0 = 64'(xl) * 64'(kl);
            p1 = 64'(xl) * 64'(kh);
            p2 = 64'(xh) * 64'(kl);
            p3 = 64'(xh) * 64'(kh);
            mn = p0;
            mx = p0;
            if (p1 < mn) mn = p1;
            if (p2 < mn) mn = p2;
            if (p3 < mn) mn = p3;
            if (p1 > mx) mx = p1;
            if (p2 > mx) mx = p2;
            if (p3 > mx) mx = p3;
            acc_lo = clamp_value(acc_lo + round_down(mn));
            acc_hi = clamp_value(acc_hi + round_up(mx));
         end
      end
      res.result_low = acc_lo[31:0];
      res.result_high = acc_hi[31:0];
      res.status = icv_pkg::STS_OK;
      return 1'b1;
   endfunction

   // driver: present pending requests with random gaps
   always @(posedge clock) begin
      icv_pkg::rsp_type res;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait <= 0;
      end else if (req_valid && !req_stall) begin
         if (predict_sum(req_data, res)) expected_sums.insert(expected_sums.size(), res);
         void'(pending_reqs.pop_front());
         req_valid <= 1'b0;
         req_wait <= $urandom_range(0, 9);
      end else if (!req_valid) begin
         if (req_wait > 0) begin
            req_wait <= req_wait - 1;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
            req_valid <= 1'b1;
         end
      end
   end

   // monitor: check results and stall at random
   always @(posedge clock) begin
      icv_pkg::rsp_type want;
      int               w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               report_mismatch("unexpected result", rsp_data[31:0], 32'h0);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_data.out_row !== want.out_row)
                  report_mismatch("out_row", rsp_data.out_row, want.out_row);
               if (rsp_data.out_col !== want.out_col)
                  report_mismatch("out_col", rsp_data.out_col, want.out_col);
               if (rsp_data.result_low !== want.result_low)
                  report_mismatch("result_low", rsp_data.result_low, want.result_low);
               if (rsp_data.result_high !== want.result_high)
                  report_mismatch("result_high", rsp_data.result_high, want.result_high);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
            w = $urandom_range(0, 9);
            rsp_wait <= w;
            rsp_stall <= (w > 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_stall <= (rsp_wait > 1);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input int unsigned val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= 7'(val);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         icv_pkg::CSR_IN_ROWS:   cfg_rows = val;
         icv_pkg::CSR_IN_COLS:   cfg_cols = val;
         icv_pkg::CSR_TAPS_ROWS: cfg_krows = val;
         icv_pkg::CSR_TAPS_COLS: cfg_kcols = val;
         icv_pkg::CSR_STEP_SIZE: cfg_step = val;
         default:                cfg_pad = val;
      endcase
   endtask

   // hold until every queued request is taken and every result is back
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_sums.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic queue_req(input logic [1:0] act, input int unsigned r, input int unsigned c,
                            input logic [31:0] lo, input logic [31:0] hi);
      icv_pkg::req_type q;
      q.action = act;
      q.row = 7'(r);
      q.col = 7'(c);
      q.value_low = lo;
      q.value_high = hi;
      pending_reqs.insert(pending_reqs.size(), q);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   // fill every store entry in the current size
   task automatic fill_stores();
      for (int r = 0; r < cfg_rows; r++)
         for (int c = 0; c < cfg_cols; c++)
            queue_req(icv_pkg::ACT_LOAD_INPUT, r, c, rand_value(), rand_value());
      for (int r = 0; r < cfg_krows; r++)
         for (int c = 0; c < cfg_kcols; c++)
            queue_req(icv_pkg::ACT_LOAD_KERNEL, r, c, rand_value(), rand_value());
   endtask

   task automatic config_phase(input int unsigned ir, input int unsigned ic,
                               input int unsigned kr, input int unsigned kc,
                               input int unsigned st, input int unsigned pd);
      wait_idle();
      write_reg(icv_pkg::CSR_IN_ROWS, ir);
      write_reg(icv_pkg::CSR_IN_COLS, ic);
      write_reg(icv_pkg::CSR_TAPS_ROWS, kr);
      write_reg(icv_pkg::CSR_TAPS_COLS, kc);
      write_reg(icv_pkg::CSR_STEP_SIZE, st);
      write_reg(icv_pkg::CSR_PAD_WIDTH, pd);
      fill_stores();
   endtask

   initial begin
      int unsigned orow, ocol, n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      error_count = 0;
      cfg_rows = 1; cfg_cols = 1; cfg_krows = 1; cfg_kcols = 1; cfg_step = 1; cfg_pad = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset sizes, extremes, out-of-range loads, unused action
      fill_stores();
      queue_req(icv_pkg::ACT_LOAD_INPUT, 0, 0, 32'h80000000, 32'h7FFFFFFF);
      queue_req(icv_pkg::ACT_LOAD_KERNEL, 0, 0, 32'h7FFFFFFF, 32'h80000000);
      queue_req(icv_pkg::ACT_COMPUTE, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_req(icv_pkg::ACT_COMPUTE, 127, 127, 0, 0);
      queue_req(icv_pkg::ACT_LOAD_INPUT, 127, 127, 32'hFFFFFFFF, 0);
      queue_req(icv_pkg::ACT_LOAD_KERNEL, 5, 0, 0, 0);
      queue_req(2'd3, 0, 0, 32'h12345678, 32'h9ABCDEF0);
      queue_req(icv_pkg::ACT_COMPUTE, 0, 1, 0, 0);
      // kernel larger than the padded input
      config_phase(2, 2, 8, 3, 1, 0);
      queue_req(icv_pkg::ACT_COMPUTE, 0, 0, 0, 0);
      // saturation: all taps at extreme magnitude
      config_phase(8, 8, 8, 8, 1, 0);
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++) begin
            queue_req(icv_pkg::ACT_LOAD_INPUT, r, c, 32'h80000000, 32'h7FFFFFFF);
            queue_req(icv_pkg::ACT_LOAD_KERNEL, r, c, 32'h7FFFFFFF, 32'h80000000);
         end
      queue_req(icv_pkg::ACT_COMPUTE, 0, 0, 0, 0);
      queue_req(icv_pkg::ACT_COMPUTE, 1, 0, 0, 0);

      // random phases; one tall and one wide input, mostly small ones
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 3) config_phase(64, 3, 8, 8, 8, 7);
         else if (ph == 7) config_phase(1, 64, 1, 8, 1, 7);
         else config_phase($urandom_range(1, 10), $urandom_range(1, 10),
                           $urandom_range(1, 8), $urandom_range(1, 8),
                           $urandom_range(1, 8), $urandom_range(0, 7));
         orow = (cfg_rows + 2 * cfg_pad >= cfg_krows) ?
                (cfg_rows + 2 * cfg_pad - cfg_krows) / cfg_step + 1 : 1;
         ocol = (cfg_cols + 2 * cfg_pad >= cfg_kcols) ?
                (cfg_cols + 2 * cfg_pad - cfg_kcols) / cfg_step + 1 : 1;
         n = (ph == 3) ? 40 : (ph == 7) ? 110 : 60;
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
               0: queue_req(icv_pkg::ACT_LOAD_INPUT, $urandom_range(0, 127),
                            $urandom_range(0, 127), rand_value(), rand_value());
               1: queue_req(icv_pkg::ACT_LOAD_KERNEL, $urandom_range(0, cfg_krows - 1),
                            $urandom_range(0, cfg_kcols - 1), rand_value(), rand_value());
               2: queue_req(icv_pkg::ACT_LOAD_INPUT, $urandom_range(0, cfg_rows - 1),
                            $urandom_range(0, cfg_cols - 1), rand_value(), rand_value());
               3: queue_req(icv_pkg::ACT_COMPUTE, $urandom_range(0, 127),
                            $urandom_range(0, 127), $urandom, $urandom);
               4: queue_req(2'd3, $urandom_range(0, 127), $urandom_range(0, 127),
                            $urandom, $urandom);
               default: queue_req(icv_pkg::ACT_COMPUTE, $urandom_range(0, orow - 1),
                                  $urandom_range(0, ocol - 1), $urandom, $urandom);
            endcase
         end
         // pause the sender until every result has come
         if (ph == 5) wait_idle();
      end
      config_phase(1, 1, 1, 1, 1, 0);
      queue_req(icv_pkg::ACT_COMPUTE, 0, 0, 0, 0);

      wait_idle();
      if (error_count == 0 && expected_sums.size() == 0) begin
         $display("tb_interval_conv2d_stride_pad_top: clean");
      end else begin
         $display("tb_interval_conv2d_stride_pad_top: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/icv_pkg.sv
hw/rtl/icv_ctrl.sv
hw/rtl/icv_datapath.sv
hw/rtl/interval_conv2d_stride_pad_top.sv
hw/rtl/icv_checker.sv
verif/tb_interval_conv2d_stride_pad_top.sv
